FILE: src/next_reaction_method_ssa_step_core_macros.svh
// Assertion macros shared by the checker of the next reaction step core.
// Depends on nothing; the using module supplies i_clk and i_rst_n.
`ifndef NEXT_REACTION_METHOD_SSA_STEP_CORE_MACROS_SVH
`define NEXT_REACTION_METHOD_SSA_STEP_CORE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define NRM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nrm check failed");

// Next-cycle implication, held off during reset.
`define NRM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nrm check failed");

`endif

FILE: src/nrm_pkg.sv
// Types and constants of the next reaction method step core.
// Used by the lanes, the merge stage, the top level and the checker.
`default_nettype none
package nrm_pkg;

    localparam int NUM_SPECIES = 7;
    localparam int NUM_RXN     = 5;
    localparam int COUNT_W     = 16;
    localparam int TIME_W      = 32;
    localparam int PROP_W      = 48;
    localparam int TIME_FRAC   = 24;
    localparam int LOG_BITS    = 28;
    localparam int NUM_W       = 80;

    localparam logic [TIME_W-1:0] NEVER   = '1;
    localparam logic [29:0]       LN2_Q30 = 30'd744261118;

    // Request commands.
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_INIT = 2'd1;
    localparam logic [1:0] CMD_FIRE = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_RATE = 1'b0;
    localparam logic CFG_END  = 1'b1;

    localparam logic [2:0] NO_SPECIES = 3'd7;

    // Reactants of each reaction.
    localparam logic [2:0] REACT_A [NUM_RXN] = '{3'd0, 3'd1, 3'd3, 3'd5, 3'd4};
    localparam logic [2:0] REACT_B [NUM_RXN] = '{3'd1, 3'd2, 3'd4, 3'd7, 3'd6};

    // Reactions whose propensity changes when a reaction fires.
    localparam logic [NUM_RXN-1:0] AFFECTS [NUM_RXN] =
        '{5'h03, 5'h07, 5'h0C, 5'h1C, 5'h15};

    // Species consumed and produced by each reaction, bit i is species i.
    localparam logic [NUM_SPECIES-1:0] DEC_MASK [NUM_RXN] =
        '{7'b0000011, 7'b0000110, 7'b0001000, 7'b0100000, 7'b1010000};
    localparam logic [NUM_SPECIES-1:0] INC_MASK [NUM_RXN] =
        '{7'b0000100, 7'b0001000, 7'b0100000, 7'b1001000, 7'b0000001};

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  species_index;
        logic [15:0] count_value;
        logic [31:0] uniform_r1;
        logic [31:0] uniform_r2;
        logic [31:0] uniform_r3;
        logic [31:0] uniform_r4;
        logic [31:0] uniform_r5;
    } t_req;

    typedef struct packed {
        logic [2:0]  fired_reaction;
        logic [31:0] event_time;
        logic        finished;
        logic [15:0] count_a;
        logic [15:0] count_b;
        logic [15:0] count_c;
        logic [15:0] count_d;
        logic [15:0] count_e;
        logic [15:0] count_f;
        logic [15:0] count_g;
    } t_rsp;

    // Command from the sequencer to one lane.
    typedef struct packed {
        logic              start;
        logic              draw;
        logic [31:0]       u;
        logic [TIME_W-1:0] cur;
    } t_lane_ctl;

    // Status of one lane.
    typedef struct packed {
        logic              busy;
        logic [TIME_W-1:0] rtime;
    } t_lane_sts;

    // What the merge stage found.
    typedef struct packed {
        logic [2:0]        mu;
        logic [TIME_W-1:0] t_min;
        logic              fire_ok;
    } t_merge;

    typedef logic [NUM_RXN-1:0][TIME_W-1:0] t_time_arr;

    typedef enum logic [2:0] {
        S_IDLE, S_COUNT, S_START, S_WAIT, S_FINISH
    } t_top_state;

    typedef enum logic [3:0] {
        L_IDLE, L_PROP1, L_PROP2, L_DECIDE, L_NORM, L_SQ, L_LN, L_MUL, L_DIV, L_ADD
    } t_lane_state;

endpackage
`default_nettype wire

FILE: src/nrm_lane.sv
// One reaction lane: propensity, putative time, log unit and serial divider.
// Depends on nrm_pkg.
`default_nettype none
module nrm_lane (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  nrm_pkg::t_lane_ctl    i_ctl,
    input  wire [15:0]            i_cnt_a,
    input  wire [15:0]            i_cnt_b,
    input  wire [15:0]            i_rate,
    output nrm_pkg::t_lane_sts    o_sts
);
    import nrm_pkg::*;

    t_lane_state r_state, n_state;

    logic [PROP_W-1:0] r_prop;
    logic [TIME_W-1:0] r_time;
    logic [PROP_W-1:0] r_pold;
    logic [31:0]       r_u;
    logic [TIME_W-1:0] r_cur;
    logic              r_draw;
    logic [31:0]       r_prod;
    logic [31:0]       r_x;
    logic [4:0]        r_e;
    logic [LOG_BITS-1:0] r_f;
    logic [6:0]        r_cnt;
    logic [PROP_W-1:0] r_a;
    logic [31:0]       r_b;
    logic [NUM_W-1:0]  r_num;
    logic [PROP_W-1:0] r_rem;
    logic [32:0]       r_q;

    // Decision terms.
    logic        draw_path;
    logic        u_zero;
    logic [63:0] sq;
    logic [32:0] sq_sh;
    logic [33:0] nl2;
    logic [63:0] ln_prod;
    logic [15:0] part;
    logic [47:0] pp;
    logic [48:0] rem_sh;
    logic        ge;
    logic [48:0] rem_sub;
    logic [33:0] t_sum;

    assign draw_path = r_draw || (r_time == NEVER) || (r_pold == '0);
    assign u_zero    = (r_u == '0);
    assign sq        = r_x * r_x;
    assign sq_sh     = sq[63:31];
    assign nl2       = {({1'b0, r_e} + 6'd1), 28'd0} - {6'd0, r_f};
    assign ln_prod   = nl2 * LN2_Q30;
    assign pp        = part * r_b;
    assign rem_sh    = {r_rem, r_num[NUM_W-1]};
    assign ge        = rem_sh >= {1'b0, r_prop};
    assign rem_sub   = rem_sh - {1'b0, r_prop};
    assign t_sum     = {2'b00, r_cur} + {1'b0, r_q};

    // Slice of the multiplicand, most significant first.
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    part = r_a[47:32];
            2'd1:    part = r_a[31:16];
            default: part = r_a[15:0];
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            L_IDLE:   if (i_ctl.start) n_state = L_PROP1;
            L_PROP1:  n_state = L_PROP2;
            L_PROP2:  n_state = L_DECIDE;
            L_DECIDE: begin
                if (draw_path) begin
                    n_state = (r_prop == '0 || u_zero) ? L_IDLE : L_NORM;
                end else begin
                    n_state = (r_prop == '0) ? L_IDLE : L_MUL;
                end
            end
            L_NORM:   if (r_x[31]) n_state = L_SQ;
            L_SQ:     if (r_cnt == 7'(LOG_BITS - 1)) n_state = L_LN;
            L_LN:     n_state = L_MUL;
            L_MUL:    if (r_cnt == 7'd2) n_state = L_DIV;
            L_DIV:    if (r_cnt == 7'(NUM_W - 1)) n_state = L_ADD;
            L_ADD:    n_state = L_IDLE;
            default:  n_state = L_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_sts.busy  = (r_state != L_IDLE);
        o_sts.rtime = r_time;
    end

    // Control state and lane state with reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_prop  <= '0;
            r_time  <= NEVER;
        end else begin
            r_state <= n_state;
            case (r_state)
                L_PROP2:  r_prop <= PROP_W'(r_prod * i_rate);
                L_DECIDE: begin
                    if (r_prop == '0 || (draw_path && u_zero)) r_time <= NEVER;
                end
                L_ADD:    r_time <= (t_sum >= {2'b00, NEVER}) ? NEVER : t_sum[31:0];
                default:  ;
            endcase
        end
    end

    // Datapath of the log unit, the multiplier and the divider.
    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE: begin
                r_u    <= i_ctl.u;
                r_cur  <= i_ctl.cur;
                r_draw <= i_ctl.draw;
                r_pold <= r_prop;
            end
            L_PROP1: r_prod <= i_cnt_a * i_cnt_b;
            L_DECIDE: begin
                r_x   <= r_u;
                r_e   <= '0;
                r_cnt <= '0;
                r_num <= '0;
                r_a   <= r_pold;
                r_b   <= (r_time > r_cur) ? r_time - r_cur : '0;
            end
            L_NORM: begin
                r_cnt <= '0;
                r_f   <= '0;
                if (!r_x[31]) begin
                    r_x <= {r_x[30:0], 1'b0};
                    r_e <= r_e + 5'd1;
                end
            end
            L_SQ: begin
                r_cnt <= r_cnt + 7'd1;
                r_f   <= {r_f[LOG_BITS-2:0], sq_sh[32]};
                r_x   <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
            end
            L_LN: begin
                r_a   <= {10'd0, ln_prod[63:26]};
                r_b   <= 32'd1 << (TIME_FRAC - 16);
                r_cnt <= '0;
                r_num <= '0;
            end
            L_MUL: begin
                r_num <= {r_num[NUM_W-17:0], 16'd0} + {32'd0, pp};
                r_cnt <= (r_cnt == 7'd2) ? 7'd0 : r_cnt + 7'd1;
                r_rem <= '0;
                r_q   <= '0;
            end
            L_DIV: begin
                r_cnt <= r_cnt + 7'd1;
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                r_rem <= ge ? rem_sub[47:0] : rem_sh[47:0];
                r_q   <= (r_q[32] || r_q[31]) ? 33'h1_0000_0000 : {r_q[31:0], ge};
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

FILE: src/nrm_merge.sv
// Merge stage: earliest putative time over all lanes, lowest index on ties.
// Depends on nrm_pkg.
`default_nettype none
module nrm_merge (
    input  nrm_pkg::t_time_arr i_times,
    input  wire [31:0]         i_end_time,
    output nrm_pkg::t_merge    o_merge
);
    import nrm_pkg::*;

    logic [2:0]        best;
    logic [TIME_W-1:0] best_t;

    // Scan the five lanes; strict compare keeps the lowest index.
    always_comb begin
        best   = 3'd0;
        best_t = i_times[0];
        for (int i = 1; i < NUM_RXN; i++) begin
            if (i_times[i] < best_t) begin
                best   = 3'(i);
                best_t = i_times[i];
            end
        end
    end

    always_comb begin
        o_merge.mu      = best;
        o_merge.t_min   = best_t;
        o_merge.fire_ok = (best_t != NEVER) && (best_t < i_end_time);
    end

endmodule
`default_nettype wire

FILE: src/next_reaction_method_ssa_step_core.sv
// Next reaction method step engine for a seven species, five reaction network.
// A load, an unused command or a fire with nothing to fire goes from idle to
// the finish state, where its response is registered, and the core returns to
// idle for the next request. An initialize or firing request starts the lanes
// it affects (a fire after a count update state) and waits until all idle. The
// affected lanes run in parallel and each steps through its propensity, the
// decision, normalizing the uniform, the log squaring loop, the log scaling,
// the partial-product multiply, its bit-serial divider and the final add. A
// lane with a zero propensity, or a drawing lane with a zero uniform, stops
// after the decision, and a rescaled lane skips the log steps, so the slowest
// active lane sets when the response is ready. One request is worked at a
// time; a finished response waits in the output register.
// Depends on nrm_pkg, nrm_lane and nrm_merge.
`default_nettype none
module next_reaction_method_ssa_step_core (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_req_valid,
    output logic          o_req_stall,
    input  nrm_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  wire           i_rsp_stall,
    output nrm_pkg::t_rsp o_rsp,
    input  wire           i_cfg_we,
    input  wire           i_cfg_index,
    input  wire [31:0]    i_cfg_data
);
    import nrm_pkg::*;

    t_top_state r_state, n_state;

    logic [15:0]        r_rate;
    logic [31:0]        r_end;
    logic [COUNT_W-1:0] r_counts [NUM_SPECIES];
    logic [TIME_W-1:0]  r_cur;
    logic [2:0]         r_mu;
    logic [2:0]         r_fired;
    logic [NUM_RXN-1:0] r_mask;
    logic [NUM_RXN-1:0] r_draw_mask;
    logic [31:0]        r_u [NUM_RXN];
    logic               r_rsp_valid;
    t_rsp               r_rsp;

    t_lane_ctl          lane_ctl [NUM_RXN];
    t_lane_sts          lane_sts [NUM_RXN];
    t_time_arr          times;
    t_merge             merge;
    logic [NUM_RXN-1:0] lane_busy;
    logic               accept;
    logic               rsp_free;

    assign accept   = i_req_valid && !o_req_stall;
    assign rsp_free = !r_rsp_valid || !i_rsp_stall;

    // Lanes, one per reaction.
    for (genvar g = 0; g < NUM_RXN; g++) begin : g_lane
        logic [15:0] cnt_b;
        if (REACT_B[g] == NO_SPECIES) begin : g_one
            assign cnt_b = 16'd1;
        end else begin : g_cnt
            assign cnt_b = r_counts[REACT_B[g]];
        end
        assign times[g]     = lane_sts[g].rtime;
        assign lane_busy[g] = lane_sts[g].busy;
        nrm_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl[g]),
            .i_cnt_a (r_counts[REACT_A[g]]),
            .i_cnt_b (cnt_b),
            .i_rate  (r_rate),
            .o_sts   (lane_sts[g])
        );
    end

    nrm_merge u_merge (
        .i_times    (times),
        .i_end_time (r_end),
        .o_merge    (merge)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= 16'd6554;
            r_end  <= 32'd1 << TIME_FRAC;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_RATE) r_rate <= i_cfg_data[15:0];
            else                         r_end  <= i_cfg_data;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.command == CMD_INIT) n_state = S_START;
                    else if (i_req.command == CMD_FIRE && merge.fire_ok) n_state = S_COUNT;
                    else n_state = S_FINISH;
                end
            end
            S_COUNT:  n_state = S_START;
            S_START:  n_state = S_WAIT;
            S_WAIT:   if (lane_busy == '0) n_state = S_FINISH;
            S_FINISH: if (rsp_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_req_stall = (r_state != S_IDLE);
        for (int i = 0; i < NUM_RXN; i++) begin
            lane_ctl[i].start = (r_state == S_START) && r_mask[i];
            lane_ctl[i].draw  = r_draw_mask[i];
            lane_ctl[i].u     = r_u[i];
            lane_ctl[i].cur   = r_cur;
        end
        o_rsp_valid = r_rsp_valid;
        o_rsp       = r_rsp;
    end

    // Control registers and state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_rsp_valid <= 1'b0;
            for (int i = 0; i < NUM_SPECIES; i++) r_counts[i] <= '0;
        end else begin
            r_state <= n_state;
            if (r_rsp_valid && !i_rsp_stall) r_rsp_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept && i_req.command == CMD_LOAD &&
                        i_req.species_index != NO_SPECIES) begin
                        r_counts[i_req.species_index] <= i_req.count_value;
                    end
                    if (accept && i_req.command == CMD_INIT) r_cur <= '0;
                    if (accept && i_req.command == CMD_FIRE && merge.fire_ok) begin
                        r_cur <= merge.t_min;
                    end
                end
                S_COUNT: begin
                    for (int i = 0; i < NUM_SPECIES; i++) begin
                        if (DEC_MASK[r_mu][i] && r_counts[i] != '0)
                            r_counts[i] <= r_counts[i] - 1'b1;
                        else if (INC_MASK[r_mu][i] && r_counts[i] != '1)
                            r_counts[i] <= r_counts[i] + 1'b1;
                    end
                end
                S_FINISH: if (rsp_free) r_rsp_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // Request capture and response payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_u[0] <= i_req.uniform_r1;
            r_u[1] <= i_req.uniform_r2;
            r_u[2] <= i_req.uniform_r3;
            r_u[3] <= i_req.uniform_r4;
            r_u[4] <= i_req.uniform_r5;
            r_mu   <= merge.mu;
            if (i_req.command == CMD_INIT) begin
                r_mask      <= '1;
                r_draw_mask <= '1;
                r_fired     <= '0;
            end else begin
                r_mask      <= AFFECTS[merge.mu];
                r_draw_mask <= NUM_RXN'(1) << merge.mu;
                r_fired     <= (i_req.command == CMD_FIRE && merge.fire_ok) ? merge.mu : 3'd0;
            end
        end
        if (r_state == S_FINISH && rsp_free) begin
            r_rsp.fired_reaction <= r_fired;
            r_rsp.event_time     <= r_cur;
            r_rsp.finished       <= !merge.fire_ok;
            r_rsp.count_a        <= r_counts[0];
            r_rsp.count_b        <= r_counts[1];
            r_rsp.count_c        <= r_counts[2];
            r_rsp.count_d        <= r_counts[3];
            r_rsp.count_e        <= r_counts[4];
            r_rsp.count_f        <= r_counts[5];
            r_rsp.count_g        <= r_counts[6];
        end
    end

endmodule
`default_nettype wire

FILE: src/nrm_checker.sv
// Port-level checks of the next reaction step core, bound to the top level.
// Depends on nrm_pkg and the assertion macro header.
`default_nettype none
`include "next_reaction_method_ssa_step_core_macros.svh"
module nrm_checker (
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           i_req_valid,
    input wire           o_req_stall,
    input wire           o_rsp_valid,
    input wire           i_rsp_stall,
    input nrm_pkg::t_rsp o_rsp
);
    import nrm_pkg::*;

    // A held response keeps its payload.
    `NRM_ASSERT_NEXT(a_rsp_hold, o_rsp_valid && i_rsp_stall, o_rsp_valid && $stable(o_rsp))

    // Only one request is worked at a time.
    `NRM_ASSERT_NEXT(a_one_req, i_req_valid && !o_req_stall, o_req_stall)

    // The fired index names a real reaction.
    `NRM_ASSERT_NOW(a_fired_range, o_rsp_valid, o_rsp.fired_reaction < 3'(NUM_RXN))

endmodule

bind next_reaction_method_ssa_step_core nrm_checker u_nrm_checker (.*);
`default_nettype wire

FILE: tb/sv/tb_next_reaction_method_ssa_step_core.sv
// Self-checking testbench for the next reaction method step core.
// Depends on nrm_pkg and next_reaction_method_ssa_step_core.
`timescale 1ns / 1ps
module tb_next_reaction_method_ssa_step_core;
    import nrm_pkg::*;

    localparam int WATCH_LIMIT = 6000;
    localparam int DRAIN_CYCLES = 300;
    localparam logic [63:0] T_NEVER = 64'hFFFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_req_valid = 1'b0;
    logic        o_req_stall;
    t_req        i_req = '0;
    logic        o_rsp_valid;
    logic        i_rsp_stall = 1'b0;
    t_rsp        o_rsp;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = '0;

    next_reaction_method_ssa_step_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid), .o_req_stall(o_req_stall), .i_req(i_req),
        .o_rsp_valid(o_rsp_valid), .i_rsp_stall(i_rsp_stall), .o_rsp(o_rsp),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Requests waiting to be driven and responses still owed by the core.
    t_req pending_reqs[$];
    t_rsp owed_rsps[$];
    int   err_cnt = 0;
    int   req_total = 0;
    int   rsp_total = 0;
    int   fire_total = 0;
    bit   quiet = 1'b0;

    // Shadow copy of the network state and the registers.
    logic [15:0] sh_rate;
    logic [63:0] sh_end;
    logic [63:0] sh_cnt [NUM_SPECIES];
    logic [63:0] sh_prop [NUM_RXN];
    logic [63:0] sh_rt [NUM_RXN];
    logic [63:0] sh_now;

    function automatic logic [63:0] scaled_quot(logic [63:0] a, logic [63:0] b,
                                               logic [63:0] c);
        logic [127:0] q;
        q = ({64'd0, a} * {64'd0, b}) / {64'd0, c};
        return (q > 128'hFFFF_FFFF) ? 64'h1_0000_0000 : q[63:0];
    endfunction

    function automatic logic [63:0] rxn_prop(int rx);
        logic [63:0] p;
        p = sh_cnt[REACT_A[rx]];
        if (REACT_B[rx] != NO_SPECIES) p = p * sh_cnt[REACT_B[rx]];
        p = p * {48'd0, sh_rate};
        return (p > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : p;
    endfunction

    // -ln(u/2^32) in Q.32 via normalize and repeated squaring of the mantissa.
    function automatic logic [63:0] neg_log(logic [31:0] u);
        logic [63:0] x;
        logic [63:0] f;
        logic [63:0] e;
        x = {32'd0, u};
        f = 0;
        e = 0;
        while (x[31] == 1'b0) begin
            x = x << 1;
            e = e + 1;
        end
        for (int i = 0; i < LOG_BITS; i++) begin
            x = (x * x) >> 31;
            if (x >= 64'h1_0000_0000) begin
                f[LOG_BITS-1-i] = 1'b1;
                x = x >> 1;
            end
        end
        return ((((e + 1) << LOG_BITS) - f) * 64'd744261118) >> 26;
    endfunction

    function automatic logic [63:0] time_plus(logic [63:0] d);
        logic [63:0] t;
        t = sh_now + d;
        return (t >= T_NEVER) ? T_NEVER : t;
    endfunction

    function automatic logic [63:0] fresh_time(logic [31:0] u, logic [63:0] p);
        if (p == 0 || u == 0) return T_NEVER;
        return time_plus(scaled_quot(neg_log(u), 64'd1 << (TIME_FRAC - 16), p));
    endfunction

    function automatic int first_rxn();
        int b;
        b = 0;
        for (int i = 1; i < NUM_RXN; i++)
            if (sh_rt[i] < sh_rt[b]) b = i;
        return b;
    endfunction

    // Apply one request to the shadow state and return the response it owes.
    function automatic t_rsp step_network(t_req r);
        logic [31:0] uni [NUM_RXN];
        logic [63:0] old_p, new_p, d;
        logic [2:0]  fired;
        int          mu;
        t_rsp        o;
        uni = '{r.uniform_r1, r.uniform_r2, r.uniform_r3, r.uniform_r4, r.uniform_r5};
        fired = 3'd0;
        if (r.command == CMD_LOAD) begin
            if (r.species_index < NUM_SPECIES) sh_cnt[r.species_index] = r.count_value;
        end else if (r.command == CMD_INIT) begin
            sh_now = 0;
            for (int i = 0; i < NUM_RXN; i++) begin
                sh_prop[i] = rxn_prop(i);
                sh_rt[i] = fresh_time(uni[i], sh_prop[i]);
            end
        end else if (r.command == CMD_FIRE) begin
            mu = first_rxn();
            if (sh_rt[mu] != T_NEVER && sh_rt[mu] < sh_end) begin
                sh_now = sh_rt[mu];
                fired = mu[2:0];
                fire_total++;
                for (int s = 0; s < NUM_SPECIES; s++) begin
                    if (DEC_MASK[mu][s] && sh_cnt[s] > 0) sh_cnt[s] = sh_cnt[s] - 1;
                    else if (INC_MASK[mu][s] && sh_cnt[s] < 65535)
                        sh_cnt[s] = sh_cnt[s] + 1;
                end
                for (int i = 0; i < NUM_RXN; i++) begin
                    if (AFFECTS[mu][i]) begin
                        old_p = sh_prop[i];
                        new_p = rxn_prop(i);
                        sh_prop[i] = new_p;
                        if (i == mu || sh_rt[i] == T_NEVER || old_p == 0) begin
                            sh_rt[i] = fresh_time(uni[i], new_p);
                        end else if (new_p == 0) begin
                            sh_rt[i] = T_NEVER;
                        end else begin
                            d = (sh_rt[i] > sh_now) ? sh_rt[i] - sh_now : 0;
                            sh_rt[i] = time_plus(scaled_quot(old_p, d, new_p));
                        end
                    end
                end
            end
        end
        mu = first_rxn();
        o.fired_reaction = fired;
        o.event_time = sh_now[31:0];
        o.finished = (sh_rt[mu] == T_NEVER || sh_rt[mu] >= sh_end);
        o.count_a = sh_cnt[0][15:0];
        o.count_b = sh_cnt[1][15:0];
        o.count_c = sh_cnt[2][15:0];
        o.count_d = sh_cnt[3][15:0];
        o.count_e = sh_cnt[4][15:0];
        o.count_f = sh_cnt[5][15:0];
        o.count_g = sh_cnt[6][15:0];
        return o;
    endfunction

    // Request driver: predicts on acceptance, then offers the next request.
    int req_gap = 0;
    always @(posedge i_clk) begin
        logic nxt_valid;
        t_req nxt_req;
        nxt_valid = i_req_valid;
        nxt_req = i_req;
        if (i_rst_n) begin
            if (i_req_valid && !o_req_stall) begin
                owed_rsps.push_back(step_network(i_req));
                req_total++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (req_gap > 0) begin
                    req_gap--;
                end else if (pending_reqs.size() > 0) begin
                    nxt_req = pending_reqs.pop_front();
                    nxt_valid = 1'b1;
                    if (!quiet && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 10);
                end
            end
            i_req_valid <= nxt_valid;
            i_req <= nxt_req;
        end
    end

    // Response monitor with random stalls and one long hold-off.
    int  rsp_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n) begin
            if (o_rsp_valid && !i_rsp_stall) begin
                rsp_total++;
                if (owed_rsps.size() == 0) begin
                    $error("unexpected response %p", o_rsp);
                    err_cnt++;
                end else begin
                    e = owed_rsps.pop_front();
                    if (o_rsp.fired_reaction !== e.fired_reaction) begin
                        $error("fired_reaction exp %0d got %0d", e.fired_reaction,
                               o_rsp.fired_reaction);
                        err_cnt++;
                    end
                    if (o_rsp.event_time !== e.event_time) begin
                        $error("event_time exp %h got %h", e.event_time, o_rsp.event_time);
                        err_cnt++;
                    end
                    if (o_rsp.finished !== e.finished) begin
                        $error("finished exp %0d got %0d", e.finished, o_rsp.finished);
                        err_cnt++;
                    end
                    if (o_rsp.count_a !== e.count_a) begin
                        $error("count_a exp %0d got %0d", e.count_a, o_rsp.count_a);
                        err_cnt++;
                    end
                    if (o_rsp.count_b !== e.count_b) begin
                        $error("count_b exp %0d got %0d", e.count_b, o_rsp.count_b);
                        err_cnt++;
                    end
                    if (o_rsp.count_c !== e.count_c) begin
                        $error("count_c exp %0d got %0d", e.count_c, o_rsp.count_c);
                        err_cnt++;
                    end
                    if (o_rsp.count_d !== e.count_d) begin
                        $error("count_d exp %0d got %0d", e.count_d, o_rsp.count_d);
                        err_cnt++;
                    end
                    if (o_rsp.count_e !== e.count_e) begin
                        $error("count_e exp %0d got %0d", e.count_e, o_rsp.count_e);
                        err_cnt++;
                    end
                    if (o_rsp.count_f !== e.count_f) begin
                        $error("count_f exp %0d got %0d", e.count_f, o_rsp.count_f);
                        err_cnt++;
                    end
                    if (o_rsp.count_g !== e.count_g) begin
                        $error("count_g exp %0d got %0d", e.count_g, o_rsp.count_g);
                        err_cnt++;
                    end
                end
            end
            // Choose the stall for the next cycle.
            if (!hold_done && rsp_total == 150) begin
                hold_done <= 1'b1;
                hold_left <= 400;
                i_rsp_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_rsp_stall <= (hold_left > 1);
            end else if (rsp_gap > 0) begin
                rsp_gap <= rsp_gap - 1;
                i_rsp_stall <= (rsp_gap > 1);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                rsp_gap <= $urandom_range(1, 10);
                i_rsp_stall <= 1'b1;
            end else begin
                i_rsp_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles without any handshake.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_req_valid && !o_req_stall) || (o_rsp_valid && !i_rsp_stall))
            idle_cycles <= 0;
        else if (pending_reqs.size() > 0 || owed_rsps.size() > 0 || i_req_valid)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_req make_req(logic [1:0] cmd, logic [2:0] idx, logic [15:0] v);
        t_req r;
        r.command = cmd;
        r.species_index = idx;
        r.count_value = v;
        r.uniform_r1 = $urandom;
        r.uniform_r2 = $urandom;
        r.uniform_r3 = $urandom;
        r.uniform_r4 = $urandom;
        r.uniform_r5 = $urandom;
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_req_valid || owed_rsps.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_RATE) sh_rate = val[15:0];
        else sh_end = {32'd0, val};
    endtask

    // One simulation run: load every species, initialize, mostly fire.
    task automatic queue_run(int n_fire, int max_cnt);
        t_req r;
        for (int s = 0; s < NUM_SPECIES; s++) begin
            case ($urandom_range(0, 9))
                0: r = make_req(CMD_LOAD, s[2:0], 16'hFFFF);
                1: r = make_req(CMD_LOAD, s[2:0], 16'($urandom));
                default: r = make_req(CMD_LOAD, s[2:0], 16'($urandom_range(0, max_cnt)));
            endcase
            pending_reqs.push_back(r);
        end
        r = make_req(CMD_INIT, 3'($urandom), 16'($urandom));
        if ($urandom_range(0, 9) == 0) r.uniform_r2 = 0;
        pending_reqs.push_back(r);
        for (int k = 0; k < n_fire; k++) begin
            case ($urandom_range(0, 19))
                0: r = make_req(CMD_LOAD, 3'($urandom), 16'($urandom_range(0, max_cnt)));
                1: r = make_req(2'd3, 3'($urandom), 16'($urandom));
                2: r = make_req(2'($urandom), 3'($urandom), 16'($urandom));
                default: r = make_req(CMD_FIRE, 3'($urandom), 16'($urandom));
            endcase
            pending_reqs.push_back(r);
        end
    endtask

    task automatic queue_phase(int n_items);
        int start;
        start = req_total + pending_reqs.size();
        while (req_total + pending_reqs.size() - start < n_items)
            queue_run($urandom_range(5, 30), $urandom_range(0, 1) ? 40 : 300);
    endtask

    initial begin
        t_req r;
        sh_rate = 16'd6554;
        sh_end = 64'd1 << TIME_FRAC;
        for (int s = 0; s < NUM_SPECIES; s++) sh_cnt[s] = 0;
        for (int i = 0; i < NUM_RXN; i++) begin
            sh_prop[i] = 0;
            sh_rt[i] = T_NEVER;
        end
        sh_now = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: fire with nothing loaded, ignored index, unused command.
        pending_reqs.push_back(make_req(CMD_FIRE, 3'd0, 16'd0));
        pending_reqs.push_back(make_req(CMD_LOAD, 3'd7, 16'hFFFF));
        pending_reqs.push_back(make_req(2'd3, 3'd2, 16'h1234));
        // Equal counts and equal uniforms give tied earliest times.
        for (int s = 0; s < NUM_SPECIES; s++)
            pending_reqs.push_back(make_req(CMD_LOAD, s[2:0], 16'd10));
        r = make_req(CMD_INIT, 3'd0, 16'd0);
        r.uniform_r2 = r.uniform_r1;
        r.uniform_r3 = r.uniform_r1;
        r.uniform_r4 = 0;
        r.uniform_r5 = r.uniform_r1;
        pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(CMD_FIRE, 3'd0, 16'd0));
        // Saturating increment of C and decrement from zero of A.
        pending_reqs.push_back(make_req(CMD_LOAD, 3'd2, 16'hFFFF));
        r = make_req(CMD_INIT, 3'd0, 16'd0);
        r.uniform_r1 = 32'hFFFF_FFFF;
        r.uniform_r2 = 32'd1;
        pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(CMD_LOAD, 3'd0, 16'd0));
        for (int k = 0; k < 4; k++) pending_reqs.push_back(make_req(CMD_FIRE, 3'd0, 16'd0));
        pending_reqs.push_back(make_req(CMD_INIT, 3'd0, 16'd0));
        wait_drained();

        // Random phases over several register settings.
        write_reg(CFG_RATE, 32'hFFFF);
        write_reg(CFG_END, 32'hFFFF_FFFF);
        queue_phase(140);
        wait_drained();
        write_reg(CFG_RATE, 32'd0);
        write_reg(CFG_END, 32'd0);
        queue_phase(60);
        wait_drained();
        write_reg(CFG_RATE, 32'd6554);
        write_reg(CFG_END, 32'h0100_0000);
        queue_phase(150);
        wait_drained();
        write_reg(CFG_RATE, $urandom_range(1, 65535));
        write_reg(CFG_END, $urandom);
        queue_phase(150);
        wait_drained();
        quiet = 1'b1;
        write_reg(CFG_RATE, $urandom_range(200, 3000));
        write_reg(CFG_END, 32'h0400_0000);
        queue_phase(180);
        wait_drained();

        $display("Covered %0d requests and %0d responses, %0d of them reactions fired,",
                 req_total, rsp_total, fire_total);
        $display("across loads, initializations, fires and five register settings.");
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
